// File: rtl/core/window_mean_sigma_gated_filter_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the windowed mean filter
// Shared forms for the concurrent checks, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef WINDOW_MEAN_SIGMA_GATED_FILTER_MACROS_SVH
`define WINDOW_MEAN_SIGMA_GATED_FILTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WMSG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wmsg: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define WMSG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wmsg: next-cycle check failed");

`endif

// File: rtl/core/wmsg_pkg.sv
// ----------------------------------------------------------------------------
// Windowed mean filter package
// Field widths, word types and the sequencer states of the filter.
// ----------------------------------------------------------------------------
package wmsg_pkg;

	localparam int CHAN_W     = 2;
	localparam int SAMPLE_W   = 24;
	localparam int SQR_W      = 2 * SAMPLE_W - 1;
	localparam int ROOT_W     = 24;
	localparam int ROOT_IN_W  = 2 * ROOT_W;
	localparam int DEV_W      = 24;
	localparam int DIFF_W     = SAMPLE_W + 1;
	localparam int GATE_W     = DEV_W + 2;
	localparam int SIGMA_GATE = 3;

	typedef struct packed {
		logic [CHAN_W-1:0]          channel;
		logic signed [SAMPLE_W-1:0] sample;
		logic                       window_end;
	} in_word_t;

	typedef struct packed {
		logic [CHAN_W-1:0]          out_channel;
		logic signed [SAMPLE_W-1:0] held_value;
		logic signed [SAMPLE_W-1:0] previous_value;
		logic [DEV_W-1:0]           deviation;
		logic                       accepted;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_DIV_MEAN,
		ST_DIV_SQ,
		ST_MEAN_SQ,
		ST_ROOT,
		ST_DONE
	} fsm_state_t;

endpackage

// File: rtl/core/wmsg_stream_if.sv
// ----------------------------------------------------------------------------
// Stream channel
// Valid and ready handshake carrying one word of the given type.
// ----------------------------------------------------------------------------
interface wmsg_stream_if #(
	parameter type word_t = logic
) ();

	logic  valid;
	logic  ready;
	word_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);

endinterface

// File: rtl/core/wmsg_sqr.sv
// ----------------------------------------------------------------------------
// Serial squarer
// Shift-and-add multiplier that squares an unsigned operand one bit a cycle.
// ----------------------------------------------------------------------------
module wmsg_sqr #(
	parameter int OP_W = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [OP_W-1:0]   operand,
	output logic              done,
	output logic [2*OP_W-1:0] product
);

	localparam int CNT_W = $clog2(OP_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [OP_W-1:0]  mc_q;
	logic [OP_W-1:0]  hi_q;
	logic [OP_W-1:0]  lo_q;
	logic [OP_W:0]    acc;

	assign acc = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mc_q} : {(OP_W + 1){1'b0}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(OP_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mc_q <= operand;
			hi_q <= '0;
			lo_q <= operand;
		end else if (busy_q) begin
			hi_q <= acc[OP_W:1];
			lo_q <= {acc[0], lo_q[OP_W-1:1]};
		end
	end

	assign done    = done_q;
	assign product = {hi_q, lo_q};

endmodule

// File: rtl/core/wmsg_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit a cycle, dividend shifted in MSB first.
// ----------------------------------------------------------------------------
module wmsg_div #(
	parameter int DVD_W = 56,
	parameter int DSR_W = 9
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [$clog2(DVD_W+1)-1:0]  steps,
	input  logic [DVD_W-1:0]            dividend,
	input  logic [DSR_W-1:0]            divisor,
	output logic                        done,
	output logic [DVD_W-1:0]            quotient
);

	localparam int STEP_W = $clog2(DVD_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [DSR_W-1:0]  dsr_q;
	logic [DSR_W-1:0]  rem_q;
	logic [DSR_W:0]    trial;
	logic [DSR_W:0]    diff;
	logic              fits;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

// File: rtl/core/wmsg_sqrt.sv
// ----------------------------------------------------------------------------
// Serial square root
// Digit-by-digit integer root, two radicand bits and one root bit a cycle.
// ----------------------------------------------------------------------------
module wmsg_sqrt #(
	parameter int RT_W = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [2*RT_W-1:0] radicand,
	output logic              done,
	output logic [RT_W-1:0]   root
);

	localparam int IN_W  = 2 * RT_W;
	localparam int CNT_W = $clog2(RT_W + 1);
	localparam int TRY_W = RT_W + 3;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IN_W-1:0]  rad_q;
	logic [RT_W:0]    rem_q;
	logic [RT_W-1:0]  root_q;
	logic [TRY_W-1:0] acc;
	logic [TRY_W-1:0] trial;
	logic [TRY_W-1:0] diff;
	logic             fits;

	assign acc   = {rem_q, rad_q[IN_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign fits  = acc >= trial;
	assign diff  = acc - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(RT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[RT_W:0] : acc[RT_W:0];
			root_q <= {root_q[RT_W-2:0], fits};
			rad_q  <= {rad_q[IN_W-3:0], 2'b00};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// File: rtl/core/window_mean_sigma_gated_filter.sv
// A window result is loaded into the output register once its closing word has passed
// the squarer, both divisions, the squaring of the mean and the root, if that register is free.
// A word that closes no window is absorbed once the serial squarer has squared its magnitude.
// For a closing word, two serial divisions, the serial mean square and the root, at two
// radicand bits a cycle, run one after another; no new word is taken until the filter is idle.
// Reset clears the sums, the count, the held values and deviations, and marks every channel new.

// ----------------------------------------------------------------------------
// Windowed mean filter with three-sigma gate
// Accumulates a window of samples and their squares, then derives the mean and
// deviation and gates the held value of the closing channel.
// ----------------------------------------------------------------------------
module window_mean_sigma_gated_filter import wmsg_pkg::*; #(
	parameter int CHANNELS   = 4,
	parameter int MAX_WINDOW = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	wmsg_stream_if.sink   samples,
	wmsg_stream_if.source results
);

	localparam int CNT_W    = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W    = SAMPLE_W + CNT_W;
	localparam int SQ_W     = SQR_W + CNT_W;
	localparam int STEP_W   = $clog2(SQ_W + 1);
	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	fsm_state_t state_q;
	fsm_state_t state_d;

	logic [SUM_W-1:0] sum_q;
	logic [SQ_W-1:0]  sq_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_inc;
	logic             close_q;

	logic signed [SAMPLE_W-1:0] held_q [CHANNELS];
	logic [DEV_W-1:0]           sdev_q [CHANNELS];
	logic [CHANNELS-1:0]        first_q;

	logic [CHAN_W-1:0]          chan_q;
	logic signed [SAMPLE_W-1:0] mean_q;
	logic [SAMPLE_W-1:0]        mean_mag_q;
	logic [SQR_W-1:0]           msq_q;
	logic [DIFF_W-1:0]          absdiff_q;
	logic                       take_q;
	logic                       out_valid_q;
	out_word_t                  out_word_q;

	logic                in_take;
	logic                chan_ok;
	logic                in_ready;
	logic                out_free;
	logic                out_load;
	logic [CH_IDX_W-1:0] idx;
	logic [SAMPLE_W-1:0] smp_mag;
	logic [SUM_W-1:0]    sum_ext;
	logic                sum_neg;
	logic [SUM_W-1:0]    sum_mag;
	logic [SAMPLE_W-1:0] quot_mag;
	logic [DIFF_W-1:0]   diff;
	logic [SQR_W-1:0]    mean_sq;
	logic [SQR_W-1:0]    variance;

	logic                sqr_start;
	logic [SAMPLE_W-1:0] sqr_op;
	logic                sqr_done;
	logic [2*SAMPLE_W-1:0] sqr_prod;

	logic              div_start;
	logic [STEP_W-1:0] div_steps;
	logic [SQ_W-1:0]   div_dvd;
	logic              div_done;
	logic [SQ_W-1:0]   div_quot;

	logic              sqrt_start;
	logic              sqrt_done;
	logic [ROOT_W-1:0] sqrt_root;

	assign in_take  = samples.valid && in_ready;
	assign chan_ok  = int'(samples.payload.channel) < CHANNELS;
	assign out_free = !out_valid_q || results.ready;
	assign idx      = CH_IDX_W'(chan_q);
	assign cnt_inc  = cnt_q + CNT_W'(1);

	assign smp_mag = samples.payload.sample[SAMPLE_W-1]
		? (~samples.payload.sample + SAMPLE_W'(1)) : samples.payload.sample;
	assign sum_ext = {{(SUM_W - SAMPLE_W){samples.payload.sample[SAMPLE_W-1]}},
		samples.payload.sample};
	assign sum_neg  = sum_q[SUM_W-1];
	assign sum_mag  = sum_neg ? (~sum_q + SUM_W'(1)) : sum_q;
	assign quot_mag = div_quot[SAMPLE_W-1:0];

	assign diff     = {mean_q[SAMPLE_W-1], mean_q} - {held_q[idx][SAMPLE_W-1], held_q[idx]};
	assign mean_sq  = sqr_prod[SQR_W-1:0];
	assign variance = (msq_q >= mean_sq) ? (msq_q - mean_sq) : '0;

	wmsg_sqr #(
		.OP_W(SAMPLE_W)
	) u_sqr (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sqr_start),
		.operand (sqr_op),
		.done    (sqr_done),
		.product (sqr_prod)
	);

	wmsg_div #(
		.DVD_W(SQ_W),
		.DSR_W(CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.steps    (div_steps),
		.dividend (div_dvd),
		.divisor  (cnt_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	wmsg_sqrt #(
		.RT_W(ROOT_W)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (ROOT_IN_W'(variance)),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_take && chan_ok) state_d = ST_SQUARE;
			end
			ST_SQUARE: begin
				if (sqr_done) state_d = close_q ? ST_DIV_MEAN : ST_IDLE;
			end
			ST_DIV_MEAN: begin
				if (div_done) state_d = ST_DIV_SQ;
			end
			ST_DIV_SQ: begin
				if (div_done) state_d = ST_MEAN_SQ;
			end
			ST_MEAN_SQ: begin
				if (sqr_done) state_d = ST_ROOT;
			end
			ST_ROOT: begin
				if (sqrt_done) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		sqr_start  = 1'b0;
		sqr_op     = smp_mag;
		div_start  = 1'b0;
		div_steps  = STEP_W'(SUM_W);
		div_dvd    = {sum_mag, {(SQ_W - SUM_W){1'b0}}};
		sqrt_start = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				sqr_start = samples.valid && chan_ok;
			end
			ST_SQUARE: begin
				div_start = sqr_done && close_q;
			end
			ST_DIV_MEAN: begin
				div_start = div_done;
				div_steps = STEP_W'(SQ_W);
				div_dvd   = sq_q;
			end
			ST_DIV_SQ: begin
				sqr_start = div_done;
				sqr_op    = mean_mag_q;
			end
			ST_MEAN_SQ: begin
				sqrt_start = sqr_done;
			end
			ST_DONE: begin
				out_load = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			sq_q        <= '0;
			cnt_q       <= '0;
			close_q     <= 1'b0;
			first_q     <= '1;
			out_valid_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				held_q[i] <= '0;
				sdev_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (in_take && chan_ok) begin
				sum_q   <= sum_q + sum_ext;
				cnt_q   <= cnt_inc;
				close_q <= samples.payload.window_end || (cnt_inc >= CNT_W'(MAX_WINDOW));
			end
			if (state_q == ST_SQUARE && sqr_done) begin
				sq_q <= sq_q + SQ_W'(sqr_prod[SQR_W-1:0]);
			end
			if (out_load) begin
				if (take_q) held_q[idx] <= mean_q;
				sdev_q[idx]  <= sqrt_root;
				first_q[idx] <= 1'b0;
				sum_q        <= '0;
				sq_q         <= '0;
				cnt_q        <= '0;
				out_valid_q  <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take && chan_ok) begin
			chan_q <= samples.payload.channel;
		end
		if (state_q == ST_DIV_MEAN && div_done) begin
			mean_q     <= sum_neg ? (~quot_mag + SAMPLE_W'(1)) : quot_mag;
			mean_mag_q <= quot_mag;
		end
		if (state_q == ST_DIV_SQ && div_done) begin
			msq_q <= div_quot[SQR_W-1:0];
		end
		if (state_q == ST_MEAN_SQ) begin
			absdiff_q <= diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
		end
		if (state_q == ST_ROOT) begin
			take_q <= first_q[idx] ||
				(GATE_W'(absdiff_q) > GATE_W'(SIGMA_GATE) * GATE_W'(sdev_q[idx]));
		end
		if (out_load) begin
			out_word_q.out_channel    <= chan_q;
			out_word_q.held_value     <= take_q ? mean_q : held_q[idx];
			out_word_q.previous_value <= held_q[idx];
			out_word_q.deviation      <= sqrt_root;
			out_word_q.accepted       <= take_q;
		end
	end

	assign samples.ready   = in_ready;
	assign results.valid   = out_valid_q;
	assign results.payload = out_word_q;

endmodule

// File: rtl/core/wmsg_checker.sv
// ----------------------------------------------------------------------------
// Windowed mean filter checker
// Watches the ports of the filter and checks its handshakes and the contents of its results.
// ----------------------------------------------------------------------------
`include "window_mean_sigma_gated_filter_macros.svh"

module wmsg_checker import wmsg_pkg::*; #(
	parameter int CHANNELS = 4
) (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_word_t  in_word,
	input logic      out_valid,
	input logic      out_ready,
	input out_word_t out_word
);

	localparam int CODES = 1 << CHAN_W;

	logic [CODES-1:0] first_q;
	logic             in_chan_ok;

	assign in_chan_ok = int'(in_word.channel) < CHANNELS;

	// A channel stays new until its first result has been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '1;
		end else if (out_valid && out_ready) begin
			first_q[out_word.out_channel] <= 1'b0;
		end
	end

	`WMSG_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_word))
	`WMSG_ASSERT_IMPL(a_first_taken, clk, arst_n, out_valid && first_q[out_word.out_channel], out_word.accepted)
	`WMSG_ASSERT_IMPL(a_reject_keeps, clk, arst_n, out_valid && !out_word.accepted, out_word.held_value == out_word.previous_value)
	`WMSG_ASSERT_NEXT(a_busy_after_take, clk, arst_n, in_valid && in_ready && in_chan_ok, !in_ready)

endmodule

bind window_mean_sigma_gated_filter wmsg_checker #(
	.CHANNELS(CHANNELS)
) u_wmsg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.in_word   (samples.payload),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_word  (results.payload)
);
